### sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, request and status codes, and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEFAULT_DEPTH     = 1024;
  localparam int DEFAULT_WORD_BITS = 32;

  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  // Request kinds. Codes above KIND_PEEK behave as a peek.
  localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_PEEK       = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the accepted request
    logic exec;      // update pointers and count, write or read the store
    logic fill;      // take the store read data into the front or back word
    logic load_out;  // load the response register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read; // the pop leaves entries behind, so a new end must be read
  } ctl_stat_t;

endpackage

### sv/deq_ifs.sv
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface deq_req_if #(
  parameter int WORD_BITS = deq_pkg::DEFAULT_WORD_BITS
);
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::KIND_BITS-1:0]  kind;
  logic signed [WORD_BITS-1:0]    push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int WORD_BITS  = deq_pkg::DEFAULT_WORD_BITS,
  parameter int COUNT_BITS = $clog2(deq_pkg::DEFAULT_DEPTH + 1)
);
  logic                            valid;
  logic                            ready;
  logic [deq_pkg::STATUS_BITS-1:0] status;
  logic signed [WORD_BITS-1:0]     popped_value;
  logic [COUNT_BITS-1:0]           entry_count;
  logic                            is_empty;
  logic signed [WORD_BITS-1:0]     front_word;
  logic signed [WORD_BITS-1:0]     back_word;

  modport source (output valid, output status, output popped_value, output entry_count,
                  output is_empty, output front_word, output back_word, input ready);
  modport sink   (input valid, input status, input popped_value, input entry_count,
                  input is_empty, input front_word, input back_word, output ready);
endinterface

### sv/deq_ram.sv
// ----------------------------------------------------------------------------
// Double-ended queue RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = deq_pkg::DEFAULT_WORD_BITS,
  parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request at a time and owns the response valid flag.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  deq_pkg::ctl_stat_t stat,
  output deq_pkg::ctl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;
  logic       out_free;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.fill     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_read ? ST_READ : ST_FIN;
      end
      ST_READ: begin
        cmd.fill   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // Wait here only while the response register still holds an untaken result.
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### sv/deq_dp.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring pointers, entry count, cached front and back words, entry store and
// the response register.
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int DEPTH     = deq_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = deq_pkg::DEFAULT_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::ctl_cmd_t                 cmd,
  output deq_pkg::ctl_stat_t                stat,
  input  logic [deq_pkg::KIND_BITS-1:0]     in_kind,
  input  logic signed [WORD_BITS-1:0]       in_push_value,
  output logic [deq_pkg::STATUS_BITS-1:0]   out_status,
  output logic signed [WORD_BITS-1:0]       out_popped_value,
  output logic [$clog2(DEPTH+1)-1:0]        out_entry_count,
  output logic                              out_is_empty,
  output logic signed [WORD_BITS-1:0]       out_front_word,
  output logic signed [WORD_BITS-1:0]       out_back_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Request register.
  logic [deq_pkg::KIND_BITS-1:0] req_kind;
  logic [WORD_BITS-1:0]          req_value;

  // Queue state. The back slot sits one behind the head when the queue is empty.
  logic [AW-1:0]        head;
  logic [AW-1:0]        tail;
  logic [CW-1:0]        count;
  logic [WORD_BITS-1:0] front;
  logic [WORD_BITS-1:0] back;

  logic [deq_pkg::STATUS_BITS-1:0] status_q;
  logic [WORD_BITS-1:0]            popped_q;

  logic [AW-1:0]        head_next;
  logic [AW-1:0]        tail_next;
  logic [CW-1:0]        count_next;
  logic [WORD_BITS-1:0] front_next;
  logic [WORD_BITS-1:0] back_next;
  logic [deq_pkg::STATUS_BITS-1:0] status_next;
  logic [WORD_BITS-1:0] popped_next;

  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        tail_inc;
  logic [AW-1:0]        tail_dec;
  logic                 is_full;
  logic                 is_zero;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  assign head_inc = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_SLOT : tail - 1'b1;
  assign is_full  = (count == FULL_CNT);
  assign is_zero  = (count == '0);

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    front_next     = front;
    back_next      = back;
    status_next    = deq_pkg::STATUS_OK;
    popped_next    = '0;
    wr_en          = 1'b0;
    wr_addr        = head_dec;
    rd_addr        = head_inc;
    stat.need_read = 1'b0;
    case (req_kind)
      deq_pkg::KIND_PUSH_FRONT: begin
        if (is_full) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + 1'b1;
          front_next = req_value;
          if (is_zero) begin
            back_next = req_value;
          end
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = tail_inc;
          tail_next  = tail_inc;
          count_next = count + 1'b1;
          back_next  = req_value;
          if (is_zero) begin
            front_next = req_value;
          end
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (is_zero) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          popped_next    = front;
          head_next      = head_inc;
          count_next     = count - 1'b1;
          rd_addr        = head_inc;
          stat.need_read = (count != CW'(1));
        end
      end
      deq_pkg::KIND_POP_BACK: begin
        if (is_zero) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          popped_next    = back;
          tail_next      = tail_dec;
          count_next     = count - 1'b1;
          rd_addr        = tail_dec;
          stat.need_read = (count != CW'(1));
        end
      end
      default: begin
        if (is_zero) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end
      end
    endcase
  end

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_deq_ram (
    .clk   (clk),
    .we    (wr_en && cmd.exec),
    .waddr (wr_addr),
    .wdata (req_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= LAST_SLOT;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind  <= in_kind;
      req_value <= in_push_value;
    end
    if (cmd.exec) begin
      front    <= front_next;
      back     <= back_next;
      status_q <= status_next;
      popped_q <= popped_next;
    end else if (cmd.fill) begin
      if (req_kind == deq_pkg::KIND_POP_FRONT) begin
        front <= rd_data;
      end else begin
        back <= rd_data;
      end
    end
    if (cmd.load_out) begin
      out_status       <= status_q;
      out_popped_value <= popped_q;
      out_entry_count  <= count;
      out_is_empty     <= is_zero;
      out_front_word   <= is_zero ? '0 : front;
      out_back_word    <= is_zero ? '0 : back;
    end
  end

endmodule

### sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed words in a ring buffer, one response per request.
// ----------------------------------------------------------------------------
//
//   Channel | Modport | Payload                                       | Handshake
//   --------+---------+-----------------------------------------------+------------
//   req     | sink    | kind, push_value                              | valid/ready
//   rsp     | source  | status, popped_value, entry_count, is_empty,  | valid/ready
//           |         | front_word, back_word                         |
//
// A request is accepted in the idle state, then executed, and its response is
// loaded in the final state; a pop that leaves entries behind passes through a
// read state before it, since the new front or back word is then read from the
// single-read-port entry store. The next request is accepted on the cycle after
// the load, so requests are worked on one at a time.
// The response register holds a result while the next request is accepted and
// worked on; only the final load step waits when that register is still full.
// Reset clears the pointers, the count and the handshake state.
// The entry store is never cleared, because only slots written by a push are
// ever read.
//
// The front and back words are cached in registers, so a push or a peek never
// reads the store. A pop hands out the cached word at once and reads the slot
// that becomes the new front or back. Unused kind codes behave as a peek.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH     = deq_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = deq_pkg::DEFAULT_WORD_BITS
) (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  deq_pkg::ctl_cmd_t  cmd;
  deq_pkg::ctl_stat_t stat;

  // The controller sequences each transaction and owns both handshakes.
  deq_ctrl u_deq_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the queue state, the store and the response payload.
  deq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_deq_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (req.kind),
    .in_push_value    (req.push_value),
    .out_status       (rsp.status),
    .out_popped_value (rsp.popped_value),
    .out_entry_count  (rsp.entry_count),
    .out_is_empty     (rsp.is_empty),
    .out_front_word   (rsp.front_word),
    .out_back_word    (rsp.back_word)
  );

endmodule

### sv/deq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
  parameter int DEPTH     = deq_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = deq_pkg::DEFAULT_WORD_BITS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [deq_pkg::STATUS_BITS-1:0] rsp_status,
  input logic [WORD_BITS-1:0]            rsp_popped_value,
  input logic [$clog2(DEPTH+1)-1:0]      rsp_entry_count,
  input logic                            rsp_is_empty,
  input logic [WORD_BITS-1:0]            rsp_front_word,
  input logic [WORD_BITS-1:0]            rsp_back_word
);

  localparam int CW = $clog2(DEPTH + 1);

  // While a response is valid, the empty flag and the entry count agree.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // An empty queue reports zero for both end words.
  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_is_empty) |-> (rsp_front_word == '0 && rsp_back_word == '0))
    else $error("end words not zero on an empty queue");

  // A dropped push leaves a full queue; a failed pop or peek leaves an empty one.
  a_status_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_status == deq_pkg::STATUS_FULL && rsp_entry_count == CW'(DEPTH))
                || (rsp_status == deq_pkg::STATUS_EMPTY && rsp_entry_count == '0
                    && rsp_popped_value == '0)
                || (rsp_status == deq_pkg::STATUS_OK && rsp_entry_count <= CW'(DEPTH))))
    else $error("status inconsistent with entry count");

  // A stalled response stays valid and holds its status, popped value, entry count and end words.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                   && $stable(rsp_popped_value) && $stable(rsp_entry_count)
                                   && $stable(rsp_front_word) && $stable(rsp_back_word)))
    else $error("response changed while stalled");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH     (DEPTH),
  .WORD_BITS (WORD_BITS)
) u_deq_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_popped_value (rsp.popped_value),
  .rsp_entry_count  (rsp.entry_count),
  .rsp_is_empty     (rsp.is_empty),
  .rsp_front_word   (rsp.front_word),
  .rsp_back_word    (rsp.back_word)
);
